FILE: rtl/xmodem_crc_receiver_core_macros.svh
// Assertion helpers for the checker file.
`ifndef XMODEM_CRC_RECEIVER_CORE_MACROS_SVH
`define XMODEM_CRC_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define XCR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("xcr check failed");

// Next-cycle implication, held off while reset is asserted.
`define XCR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("xcr check failed");

`endif

FILE: rtl/xcr_pkg.sv
`timescale 1ns / 1ps

package xcr_pkg;

    localparam int DEF_SHORT_BLOCK = 128;
    localparam int DEF_LONG_BLOCK  = 1024;

    // Most words one input word can cause.
    localparam int MAX_RES   = 6;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] RETRY_LIMIT_RST   = 8'd60;
    localparam logic [7:0] STARTUP_LIMIT_RST = 8'd120;

    // Config register indexes
    localparam logic REG_RETRY_LIMIT   = 1'b0;
    localparam logic REG_STARTUP_LIMIT = 1'b1;

    // Input modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_REPLY   = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // Verdicts
    localparam logic [7:0] VERD_OK   = 8'd0;
    localparam logic [7:0] VERD_DUP  = 8'd1;
    localparam logic [7:0] VERD_CRC  = 8'd2;

    // Session end codes
    localparam logic [7:0] END_DONE        = 8'd0;
    localparam logic [7:0] END_SENDER_CAN  = 8'd1;
    localparam logic [7:0] END_RECV_CAN    = 8'd2;
    localparam logic [7:0] END_ABORT       = 8'd3;

    // Line bytes
    localparam logic [7:0] B_SOH   = 8'h01;
    localparam logic [7:0] B_STX   = 8'h02;
    localparam logic [7:0] B_ABORT = 8'h03;
    localparam logic [7:0] B_EOT   = 8'h04;
    localparam logic [7:0] B_ACK   = 8'h06;
    localparam logic [7:0] B_NAK   = 8'h15;
    localparam logic [7:0] B_CAN   = 8'h18;
    localparam logic [7:0] B_C     = 8'h43;

    // CRC-16/XMODEM, one byte, msb first
    function automatic logic [15:0] xcr_crc16(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/xmodem_crc_receiver_core.sv
`timescale 1ns / 1ps

// XMODEM-CRC / 1K-XMODEM receiver core.
// Input channel (s_valid/s_ready): s_mode 0 starts a session, 1 delivers a byte
// from the serial line in s_rx_byte, 2 is a one-second timeout tick.
// Result channel (m_valid/m_ready): each word carries m_kind (reply byte, payload
// byte, frame verdict, session end), m_value and m_last, which marks the final
// word caused by one input word. An input word causes zero to six result words.
// Config port: cfg_we writes cfg_wdata into register cfg_index (0 retry_limit,
// 1 startup_limit) in the same cycle; write only while the core is idle.
// An accepted word is registered in the input register, then decoded into the
// result buffer, a second register, whose words drive m_*.
// Throughput: one input word per cycle while each causes at most one result and
// m_ready is high; a word that causes more waits while the result buffer drains
// one word per cycle while m_ready is high. A stalled m_ready holds the buffer;
// one more input word waits in the input register and s_ready then drops.
// Reset (aresetn low, synchronous) empties both registers, returns the session
// to idle and loads retry_limit 60 and startup_limit 120.
module xmodem_crc_receiver_core
    import xcr_pkg::*;
#(
    parameter int SHORT_BLOCK = DEF_SHORT_BLOCK,
    parameter int LONG_BLOCK  = DEF_LONG_BLOCK
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_rx_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_value,
    output logic       m_last,

    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata
);

    localparam int MAX_BLOCK = (LONG_BLOCK > SHORT_BLOCK) ? LONG_BLOCK : SHORT_BLOCK;
    localparam int CNT_W     = $clog2(MAX_BLOCK);
    localparam logic [CNT_W:0] SHORT_LEN = (CNT_W + 1)'(SHORT_BLOCK);
    localparam logic [CNT_W:0] LONG_LEN  = (CNT_W + 1)'(LONG_BLOCK);

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_HEAD, PH_SEQ, PH_CSEQ, PH_DATA, PH_CRCH, PH_CRCL
    } phase_t;

    // config
    logic [7:0] retry_limit_reg, startup_limit_reg;

    // session state
    phase_t           phase_reg,        phase_next;
    logic [7:0]       expected_seq_reg, expected_seq_next;
    logic             long_frame_reg,   long_frame_next;
    logic [CNT_W-1:0] byte_count_reg,   byte_count_next;
    logic [15:0]      crc_acc_reg,      crc_acc_next;
    logic [7:0]       got_seq_reg,      got_seq_next;
    logic [7:0]       crc_high_reg,     crc_high_next;
    logic             dup_reg,          dup_next;
    logic [7:0]       retry_count_reg,  retry_count_next;
    logic [7:0]       start_count_reg,  start_count_next;

    // input register
    logic       in_valid_reg;
    logic [1:0] in_mode_reg;
    logic [7:0] in_byte_reg;

    // result buffer
    logic [1:0]           buf_kind_reg  [MAX_RES];
    logic [7:0]           buf_value_reg [MAX_RES];
    logic [RES_CNT_W-1:0] buf_cnt_reg;
    logic [RES_IDX_W-1:0] buf_idx_reg;

    logic [1:0]           res_kind  [MAX_RES];
    logic [7:0]           res_value [MAX_RES];
    logic [RES_CNT_W-1:0] res_n;

    logic             proc_fire;
    logic             err, cancel, clear, start;
    logic [7:0]       retry_inc;
    logic [CNT_W:0]   count_inc;
    logic [CNT_W:0]   frame_len;

    assign m_valid   = (buf_cnt_reg != '0);
    assign m_kind    = buf_kind_reg[buf_idx_reg];
    assign m_value   = buf_value_reg[buf_idx_reg];
    assign m_last    = ((RES_CNT_W)'(buf_idx_reg) + 1'b1) == buf_cnt_reg;
    assign proc_fire = in_valid_reg && (!m_valid || (m_ready && m_last));
    assign s_ready   = !in_valid_reg || proc_fire;

    assign retry_inc = retry_count_reg + 8'd1;
    assign count_inc = {1'b0, byte_count_reg} + 1'b1;
    assign frame_len = long_frame_reg ? LONG_LEN : SHORT_LEN;

    always_comb begin
        phase_next        = phase_reg;
        expected_seq_next = expected_seq_reg;
        long_frame_next   = long_frame_reg;
        byte_count_next   = byte_count_reg;
        crc_acc_next      = crc_acc_reg;
        got_seq_next      = got_seq_reg;
        crc_high_next     = crc_high_reg;
        dup_next          = dup_reg;
        retry_count_next  = retry_count_reg;
        start_count_next  = start_count_reg;
        res_kind  = '{default: '0};
        res_value = '{default: '0};
        res_n     = '0;
        err       = 1'b0;
        cancel    = 1'b0;
        clear     = 1'b0;
        start     = 1'b0;

        if (proc_fire) begin
            case (in_mode_reg)
                MODE_START: start = 1'b1;
                MODE_BYTE: begin
                    case (phase_reg)
                        PH_START: begin
                            if (in_byte_reg == B_SOH || in_byte_reg == B_STX) begin
                                long_frame_next = (in_byte_reg == B_STX);
                                phase_next      = PH_SEQ;
                            end else if (in_byte_reg == B_ABORT) begin
                                res_kind[res_n[RES_IDX_W-1:0]]  = KIND_END;
                                res_value[res_n[RES_IDX_W-1:0]] = END_ABORT;
                                res_n = res_n + 1'b1;
                                clear = 1'b1;
                            end
                        end
                        PH_HEAD: begin
                            if (in_byte_reg == B_SOH || in_byte_reg == B_STX) begin
                                long_frame_next = (in_byte_reg == B_STX);
                                phase_next      = PH_SEQ;
                            end else if (in_byte_reg == B_EOT) begin
                                res_kind[res_n[RES_IDX_W-1:0]]  = KIND_REPLY;
                                res_value[res_n[RES_IDX_W-1:0]] = B_ACK;
                                res_n = res_n + 1'b1;
                                res_kind[res_n[RES_IDX_W-1:0]]  = KIND_END;
                                res_value[res_n[RES_IDX_W-1:0]] = END_DONE;
                                res_n = res_n + 1'b1;
                                clear = 1'b1;
                            end else if (in_byte_reg == B_CAN) begin
                                res_kind[res_n[RES_IDX_W-1:0]]  = KIND_END;
                                res_value[res_n[RES_IDX_W-1:0]] = END_SENDER_CAN;
                                res_n = res_n + 1'b1;
                                clear = 1'b1;
                            end else begin
                                err = 1'b1;
                            end
                        end
                        PH_SEQ: begin
                            got_seq_next = in_byte_reg;
                            phase_next   = PH_CSEQ;
                        end
                        PH_CSEQ: begin
                            if (got_seq_reg != ~in_byte_reg) begin
                                err = 1'b1;
                            end else if (got_seq_reg == expected_seq_reg ||
                                         got_seq_reg == expected_seq_reg - 8'd1) begin
                                dup_next        = (got_seq_reg != expected_seq_reg);
                                byte_count_next = '0;
                                crc_acc_next    = '0;
                                phase_next      = PH_DATA;
                            end else begin
                                cancel = 1'b1;
                            end
                        end
                        PH_DATA: begin
                            crc_acc_next = xcr_crc16(crc_acc_reg, in_byte_reg);
                            if (!dup_reg) begin
                                res_kind[res_n[RES_IDX_W-1:0]]  = KIND_DATA;
                                res_value[res_n[RES_IDX_W-1:0]] = in_byte_reg;
                                res_n = res_n + 1'b1;
                            end
                            if (count_inc >= frame_len) begin
                                byte_count_next = '0;
                                phase_next      = PH_CRCH;
                            end else begin
                                byte_count_next = count_inc[CNT_W-1:0];
                            end
                        end
                        PH_CRCH: begin
                            crc_high_next = in_byte_reg;
                            phase_next    = PH_CRCL;
                        end
                        PH_CRCL: begin
                            if (dup_reg) begin
                                dup_next         = 1'b0;
                                retry_count_next = '0;
                                res_kind[res_n[RES_IDX_W-1:0]]  = KIND_VERDICT;
                                res_value[res_n[RES_IDX_W-1:0]] = VERD_DUP;
                                res_n = res_n + 1'b1;
                                res_kind[res_n[RES_IDX_W-1:0]]  = KIND_REPLY;
                                res_value[res_n[RES_IDX_W-1:0]] = B_ACK;
                                res_n = res_n + 1'b1;
                                phase_next = PH_HEAD;
                            end else if (crc_high_reg == crc_acc_reg[15:8] &&
                                         in_byte_reg == crc_acc_reg[7:0]) begin
                                retry_count_next  = '0;
                                expected_seq_next = expected_seq_reg + 8'd1;
                                res_kind[res_n[RES_IDX_W-1:0]]  = KIND_VERDICT;
                                res_value[res_n[RES_IDX_W-1:0]] = VERD_OK;
                                res_n = res_n + 1'b1;
                                res_kind[res_n[RES_IDX_W-1:0]]  = KIND_REPLY;
                                res_value[res_n[RES_IDX_W-1:0]] = B_ACK;
                                res_n = res_n + 1'b1;
                                phase_next = PH_HEAD;
                            end else begin
                                res_kind[res_n[RES_IDX_W-1:0]]  = KIND_VERDICT;
                                res_value[res_n[RES_IDX_W-1:0]] = VERD_CRC;
                                res_n = res_n + 1'b1;
                                err = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                MODE_TICK: begin
                    case (phase_reg)
                        PH_START: begin
                            if (start_count_reg >= startup_limit_reg) begin
                                cancel = 1'b1;
                            end else begin
                                start_count_next = start_count_reg + 8'd1;
                                res_kind[res_n[RES_IDX_W-1:0]]  = KIND_REPLY;
                                res_value[res_n[RES_IDX_W-1:0]] = B_C;
                                res_n = res_n + 1'b1;
                            end
                        end
                        PH_HEAD, PH_SEQ, PH_CSEQ, PH_DATA, PH_CRCH, PH_CRCL: begin
                            dup_next = 1'b0;
                            err      = 1'b1;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        if (err) begin
            retry_count_next = retry_inc;
            if (retry_inc >= retry_limit_reg) begin
                cancel = 1'b1;
            end else begin
                res_kind[res_n[RES_IDX_W-1:0]]  = KIND_REPLY;
                res_value[res_n[RES_IDX_W-1:0]] = B_NAK;
                res_n = res_n + 1'b1;
                phase_next = PH_HEAD;
            end
        end

        if (cancel) begin
            for (int i = 0; i < 4; i++) begin
                res_kind[res_n[RES_IDX_W-1:0]]  = KIND_REPLY;
                res_value[res_n[RES_IDX_W-1:0]] = B_CAN;
                res_n = res_n + 1'b1;
            end
            res_kind[res_n[RES_IDX_W-1:0]]  = KIND_END;
            res_value[res_n[RES_IDX_W-1:0]] = END_RECV_CAN;
            res_n = res_n + 1'b1;
            clear = 1'b1;
        end

        if (clear || start) begin
            phase_next        = PH_IDLE;
            expected_seq_next = 8'd1;
            long_frame_next   = 1'b0;
            byte_count_next   = '0;
            crc_acc_next      = '0;
            got_seq_next      = '0;
            crc_high_next     = '0;
            dup_next          = 1'b0;
            retry_count_next  = '0;
            start_count_next  = '0;
        end

        if (start) begin
            phase_next       = PH_START;
            start_count_next = 8'd1;
            res_kind[res_n[RES_IDX_W-1:0]]  = KIND_REPLY;
            res_value[res_n[RES_IDX_W-1:0]] = B_C;
            res_n = res_n + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_limit_reg   <= RETRY_LIMIT_RST;
            startup_limit_reg <= STARTUP_LIMIT_RST;
            phase_reg         <= PH_IDLE;
            expected_seq_reg  <= 8'd1;
            long_frame_reg    <= 1'b0;
            byte_count_reg    <= '0;
            crc_acc_reg       <= '0;
            got_seq_reg       <= '0;
            crc_high_reg      <= '0;
            dup_reg           <= 1'b0;
            retry_count_reg   <= '0;
            start_count_reg   <= '0;
            in_valid_reg      <= 1'b0;
            buf_cnt_reg       <= '0;
            buf_idx_reg       <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_RETRY_LIMIT:   retry_limit_reg   <= cfg_wdata;
                    REG_STARTUP_LIMIT: startup_limit_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            phase_reg        <= phase_next;
            expected_seq_reg <= expected_seq_next;
            long_frame_reg   <= long_frame_next;
            byte_count_reg   <= byte_count_next;
            crc_acc_reg      <= crc_acc_next;
            got_seq_reg      <= got_seq_next;
            crc_high_reg     <= crc_high_next;
            dup_reg          <= dup_next;
            retry_count_reg  <= retry_count_next;
            start_count_reg  <= start_count_next;

            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end

            // a new buffer load only happens once the previous one is drained
            if (proc_fire) begin
                buf_cnt_reg <= res_n;
                buf_idx_reg <= '0;
            end else if (m_valid && m_ready) begin
                if (m_last) begin
                    buf_cnt_reg <= '0;
                    buf_idx_reg <= '0;
                end else begin
                    buf_idx_reg <= buf_idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg <= s_mode;
            in_byte_reg <= s_rx_byte;
        end
        if (proc_fire) begin
            buf_kind_reg  <= res_kind;
            buf_value_reg <= res_value;
        end
    end

endmodule

FILE: rtl/xcr_checker.sv
`timescale 1ns / 1ps
`include "xmodem_crc_receiver_core_macros.svh"

module xcr_checker
    import xcr_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_kind,
    input logic [7:0] m_value,
    input logic       m_last
);

    // stalled result word holds
    `XCR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_value) && $stable(m_last))

    // a session end always closes its group
    `XCR_ASSERT_NOW(a_end_last, aclk, aresetn, m_valid && m_kind == KIND_END, m_last)

    // a verdict is always followed by ACK, NAK or the cancel sequence
    `XCR_ASSERT_NOW(a_verdict_not_last, aclk, aresetn, m_valid && m_kind == KIND_VERDICT, !m_last)

    // a payload byte is the only word its input byte causes
    `XCR_ASSERT_NOW(a_data_alone, aclk, aresetn, m_valid && m_kind == KIND_DATA, m_last)

endmodule

bind xmodem_crc_receiver_core xcr_checker u_xcr_checker (.*);
